### rtl/core/lcfp_pkg.sv
package lcfp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd2;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h00;
  localparam logic [BYTE_W-1:0] MAX_LEN_RST    = 8'd125;
  localparam logic [TICK_W-1:0] TIMEOUT_RST    = 16'd20;
  localparam logic [TICK_W-1:0] IDLE_MAX       = 16'hFFFF;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } lcfp_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] max_length;
    logic [TICK_W-1:0] timeout_ticks;
  } lcfp_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic [BYTE_W-1:0] position;
    logic              is_last;
    logic              checksum_ok;
    logic              aborted;
  } lcfp_result_t;

endpackage

### rtl/core/lcfp_cfg_regs.sv
module lcfp_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [lcfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcfp_pkg::CFG_W-1:0]           cfg_wdata,
  output lcfp_pkg::lcfp_cfg_t                  cfg
);
  import lcfp_pkg::*;

  lcfp_cfg_t cfg_r;
  lcfp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_START:   cfg_nxt.start_byte    = cfg_wdata[BYTE_W-1:0];
        CFG_IDX_MAX_LEN: cfg_nxt.max_length    = cfg_wdata[BYTE_W-1:0];
        CFG_IDX_TIMEOUT: cfg_nxt.timeout_ticks = cfg_wdata[TICK_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= START_BYTE_RST;
      cfg_r.max_length    <= MAX_LEN_RST;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/lcfp_parser.sv
module lcfp_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcfp_pkg::lcfp_cfg_t           cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [lcfp_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                          res_space,
  output logic                          res_push,
  output lcfp_pkg::lcfp_result_t        res
);
  import lcfp_pkg::*;

  logic              in_vld_r;
  logic              in_mode_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_vld_nxt;

  lcfp_phase_t       phase_r, phase_nxt;
  logic [BYTE_W-1:0] count_r, count_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [TICK_W-1:0] idle_r, idle_nxt;

  logic              emit;
  logic              advance;
  logic              timed_out;
  logic              frame_open;
  logic              is_start;
  logic [BYTE_W:0]   pos_inc;

  assign timed_out  = (idle_r >= cfg.timeout_ticks);
  assign frame_open = (phase_r == PH_LENGTH) || (phase_r == PH_BODY);
  assign is_start   = (in_byte_r == cfg.start_byte);
  assign pos_inc    = {1'b0, count_r} + {{BYTE_W{1'b0}}, 1'b1};

  always_comb begin
    emit = 1'b0;
    res  = '0;
    if (in_mode_r == MODE_BYTE) begin
      if (timed_out) begin
        emit        = frame_open;
        res.aborted = 1'b1;
      end else if (phase_r == PH_BODY) begin
        emit          = 1'b1;
        res.body_byte = in_byte_r;
        res.position  = count_r;
        if (pos_inc >= {1'b0, len_r}) begin
          res.is_last     = 1'b1;
          res.checksum_ok = (sum_r == in_byte_r);
        end
      end
    end
  end

  assign advance  = in_vld_r && (!emit || res_space);
  assign res_push = advance && emit;
  assign in_ready = !in_vld_r || advance;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    idle_nxt  = idle_r;
    if (advance) begin
      if (in_mode_r == MODE_TICK) begin
        if (idle_r != IDLE_MAX) begin
          idle_nxt = idle_r + {{(TICK_W-1){1'b0}}, 1'b1};
        end
      end else begin
        idle_nxt = '0;
        if (timed_out) begin
          phase_nxt = is_start ? PH_LENGTH : PH_START;
          if (is_start) begin
            sum_nxt = in_byte_r;
          end
        end else begin
          unique case (phase_r)
            PH_LENGTH: begin
              if (in_byte_r == '0 || in_byte_r > cfg.max_length) begin
                phase_nxt = PH_START;
              end else begin
                len_nxt   = in_byte_r;
                sum_nxt   = sum_r + in_byte_r;
                count_nxt = '0;
                phase_nxt = PH_BODY;
              end
            end
            PH_BODY: begin
              if (pos_inc >= {1'b0, len_r}) begin
                phase_nxt = PH_START;
                count_nxt = '0;
              end else begin
                sum_nxt   = sum_r + in_byte_r;
                count_nxt = pos_inc[BYTE_W-1:0];
              end
            end
            default: begin
              phase_nxt = is_start ? PH_LENGTH : PH_START;
              if (is_start) begin
                sum_nxt = in_byte_r;
              end
            end
          endcase
        end
      end
    end
  end

  assign in_vld_nxt = in_ready ? in_valid : in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      phase_r  <= PH_START;
      count_r  <= '0;
      len_r    <= '0;
      sum_r    <= '0;
      idle_r   <= IDLE_MAX;
    end else begin
      in_vld_r <= in_vld_nxt;
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      len_r    <= len_nxt;
      sum_r    <= sum_nxt;
      idle_r   <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_mode_r <= in_mode;
      in_byte_r <= in_rx_byte;
    end
  end

endmodule

### rtl/core/lcfp_out_reg.sv
module lcfp_out_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    res_push,
  input  lcfp_pkg::lcfp_result_t  res,
  output logic                    res_space,
  output logic                    out_valid,
  input  logic                    out_ready,
  output lcfp_pkg::lcfp_result_t  out_res
);
  import lcfp_pkg::*;

  logic         vld_r, vld_nxt;
  lcfp_result_t data_r;

  assign res_space = !vld_r || out_ready;
  assign vld_nxt   = res_push || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      data_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = data_r;

endmodule

### rtl/core/length_checksum_frame_parser.sv
// Length-prefixed frame parser with an 8-bit additive checksum. Each input beat is either a
// received byte (in_mode 0) or a one-millisecond tick (in_mode 1). A frame is the start byte,
// a length byte L in 1..max_length, then L body bytes; every body byte comes out with its
// position, and the last one carries is_last and checksum_ok (sum of all earlier frame bytes,
// start and length included, modulo 256). A byte that follows timeout_ticks or more ticks of
// silence restarts the start-byte search; if a frame was open, one beat with only aborted set
// is sent. One beat is taken per cycle unless a result waits for room: each beat passes an
// input register, step logic on the running sum and counters, and an output register, so a
// result is offered once the output register holds it. Beats that make no result keep flowing
// while a result waits; a beat that makes a result holds in the input register, and stalls
// the input, until the output register has room. Write the configuration registers only
// while the block is idle.
module length_checksum_frame_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lcfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcfp_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [lcfp_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lcfp_pkg::BYTE_W-1:0]         out_body_byte,
  output logic [lcfp_pkg::BYTE_W-1:0]         out_position,
  output logic                                out_is_last,
  output logic                                out_checksum_ok,
  output logic                                out_aborted
);
  import lcfp_pkg::*;

  lcfp_cfg_t    cfg;
  lcfp_result_t res;
  lcfp_result_t out_res;
  logic         res_push;
  logic         res_space;

  lcfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcfp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .res_space  (res_space),
    .res_push   (res_push),
    .res        (res)
  );

  lcfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_space (res_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_body_byte   = out_res.body_byte;
  assign out_position    = out_res.position;
  assign out_is_last     = out_res.is_last;
  assign out_checksum_ok = out_res.checksum_ok;
  assign out_aborted     = out_res.aborted;

endmodule

### rtl/core/lcfp_checker.sv
module lcfp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lcfp_pkg::BYTE_W-1:0]    out_body_byte,
  input logic [lcfp_pkg::BYTE_W-1:0]    out_position,
  input logic                           out_is_last,
  input logic                           out_checksum_ok,
  input logic                           out_aborted
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_body_byte) && $stable(out_position)
      && $stable(out_is_last) && $stable(out_checksum_ok) && $stable(out_aborted))
    else $error("stalled result beat changed");

  a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_aborted |-> out_body_byte == '0 && out_position == '0
      && !out_is_last && !out_checksum_ok)
    else $error("aborted beat carries body data");

  a_ok_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_ok |-> out_is_last)
    else $error("checksum verdict on a non-final beat");

endmodule

bind length_checksum_frame_parser lcfp_checker u_lcfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_body_byte   (out_body_byte),
  .out_position    (out_position),
  .out_is_last     (out_is_last),
  .out_checksum_ok (out_checksum_ok),
  .out_aborted     (out_aborted)
);

### tb/tb_length_checksum_frame_parser.sv
`timescale 1ns / 100ps

module tb_length_checksum_frame_parser;
  import lcfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 300;

  typedef struct {
    logic              mode;
    logic [BYTE_W-1:0] rx;
  } rx_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = MODE_BYTE;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    out_body_byte;
  logic [BYTE_W-1:0]    out_position;
  logic                 out_is_last;
  logic                 out_checksum_ok;
  logic                 out_aborted;

  length_checksum_frame_parser uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_body_byte   (out_body_byte),
    .out_position    (out_position),
    .out_is_last     (out_is_last),
    .out_checksum_ok (out_checksum_ok),
    .out_aborted     (out_aborted)
  );

  always #4 clk = ~clk;

  // parser copy: settings and framing state
  logic [BYTE_W-1:0] start_code    = START_BYTE_RST;
  logic [BYTE_W-1:0] len_limit     = MAX_LEN_RST;
  logic [TICK_W-1:0] silence_limit = TIMEOUT_RST;
  lcfp_phase_t       frame_phase   = PH_START;
  logic [BYTE_W-1:0] body_cnt      = '0;
  logic [BYTE_W-1:0] frm_len       = '0;
  logic [BYTE_W-1:0] run_sum       = '0;
  logic [TICK_W-1:0] idle_cnt      = IDLE_MAX;

  rx_beat_t     pending_beats[$];
  lcfp_result_t awaited_results[$];
  lcfp_result_t want;
  rx_beat_t     nxt;

  int unsigned queued_total = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          in_taken = 1'b0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, exp_val, $time);
    errors++;
  endtask

  task automatic hunt_start(input logic [BYTE_W-1:0] b);
    if (b == start_code) begin
      run_sum = b;
      frame_phase = PH_LENGTH;
    end else begin
      frame_phase = PH_START;
    end
  endtask

  task automatic parse_step(input logic mode, input logic [BYTE_W-1:0] b);
    logic         timed_out;
    logic         open;
    lcfp_result_t r;
    r = '0;
    if (mode == MODE_TICK) begin
      if (idle_cnt != IDLE_MAX) idle_cnt = idle_cnt + 1'b1;
    end else begin
      timed_out = idle_cnt >= silence_limit;
      idle_cnt = '0;
      if (timed_out) begin
        open = (frame_phase == PH_LENGTH) || (frame_phase == PH_BODY);
        hunt_start(b);
        if (open) begin
          r.aborted = 1'b1;
          awaited_results.push_back(r);
        end
      end else begin
        case (frame_phase)
          PH_LENGTH: begin
            if (b == 0 || b > len_limit) begin
              frame_phase = PH_START;
            end else begin
              frm_len = b;
              run_sum = run_sum + b;
              body_cnt = '0;
              frame_phase = PH_BODY;
            end
          end
          PH_BODY: begin
            r.body_byte = b;
            r.position = body_cnt;
            if ({1'b0, body_cnt} + 9'd1 >= {1'b0, frm_len}) begin
              r.is_last = 1'b1;
              r.checksum_ok = (run_sum == b);
              frame_phase = PH_START;
              body_cnt = '0;
            end else begin
              run_sum = run_sum + b;
              body_cnt = body_cnt + 1'b1;
            end
            awaited_results.push_back(r);
          end
          default: hunt_start(b);
        endcase
      end
    end
  endtask

  task automatic push_beat(input logic mode, input logic [BYTE_W-1:0] b);
    rx_beat_t t;
    t.mode = mode;
    t.rx = b;
    pending_beats.push_back(t);
    queued_total++;
  endtask

  function automatic int pick_length();
    int top;
    top = (len_limit == 0) ? 8 : int'(len_limit);
    if ($urandom_range(0, 39) == 0) return top;
    return $urandom_range(1, (top < 12) ? top : 12);
  endfunction

  task automatic push_frame(input int len, input bit good);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] d;
    int                k;
    push_beat(MODE_BYTE, start_code);
    push_beat(MODE_BYTE, len[7:0]);
    sum = start_code + len[7:0];
    for (k = 0; k < len - 1; k++) begin
      if (silence_limit > 1 && $urandom_range(0, 15) == 0)
        push_beat(MODE_TICK, 8'($urandom));
      d = 8'($urandom);
      push_beat(MODE_BYTE, d);
      sum = sum + d;
    end
    push_beat(MODE_BYTE, good ? sum : 8'($urandom));
  endtask

  task automatic queue_traffic(input int unsigned count);
    int unsigned target;
    int          pick;
    int          len;
    target = queued_total + count;
    while (queued_total < target) begin
      pick = $urandom_range(0, 15);
      if (pick < 9) begin
        push_frame(pick_length(), $urandom_range(0, 3) != 0);
      end else if (pick < 11) begin
        repeat ($urandom_range(1, 24)) push_beat(MODE_TICK, 8'($urandom));
      end else if (pick < 13) begin
        // cut a frame short, then, if the timeout is at most 40 ticks, go silent long enough to time out
        len = pick_length();
        push_beat(MODE_BYTE, start_code);
        push_beat(MODE_BYTE, len[7:0]);
        repeat ($urandom_range(0, len - 1)) push_beat(MODE_BYTE, 8'($urandom));
        if (silence_limit <= 40) repeat (silence_limit) push_beat(MODE_TICK, 8'($urandom));
      end else if (pick == 13) begin
        push_beat(MODE_BYTE, 8'($urandom));
      end else begin
        push_beat(MODE_BYTE, start_code);
        if (len_limit < 255 && $urandom_range(0, 1) == 1)
          push_beat(MODE_BYTE, 8'($urandom_range(len_limit + 1, 255)));
        else
          push_beat(MODE_BYTE, 8'h00);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_IDX_START:   start_code = data[BYTE_W-1:0];
      CFG_IDX_MAX_LEN: len_limit = data[BYTE_W-1:0];
      CFG_IDX_TIMEOUT: silence_limit = data[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] ml,
                               input logic [TICK_W-1:0] to);
    write_reg(CFG_IDX_START, CFG_W'(sb));
    write_reg(CFG_IDX_MAX_LEN, CFG_W'(ml));
    write_reg(CFG_IDX_TIMEOUT, to);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // sender: present the next beat at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (!calm && pending_beats.size() != 0 && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        nxt = pending_beats.pop_front();
        in_valid <= 1'b1;
        in_mode <= nxt.mode;
        in_rx_byte <= nxt.rx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) parse_step(in_mode, in_rx_byte);
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result beat", out_body_byte, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_body_byte !== want.body_byte)
            report_mismatch("body_byte", out_body_byte, want.body_byte);
          if (out_position !== want.position)
            report_mismatch("position", out_position, want.position);
          if (out_is_last !== want.is_last)
            report_mismatch("is_last", out_is_last, want.is_last);
          if (out_checksum_ok !== want.checksum_ok)
            report_mismatch("checksum_ok", out_checksum_ok, want.checksum_ok);
          if (out_aborted !== want.aborted)
            report_mismatch("aborted", out_aborted, want.aborted);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    load_settings(8'hA5, 8'd8, 16'd2);
    push_beat(MODE_TICK, 8'hFF);
    // full frame with extreme body bytes
    push_beat(MODE_BYTE, 8'hA5);
    push_beat(MODE_BYTE, 8'h03);
    push_beat(MODE_BYTE, 8'h00);
    push_beat(MODE_BYTE, 8'hFF);
    push_beat(MODE_BYTE, 8'hA7);
    // zero length, then length above the limit
    push_beat(MODE_BYTE, 8'hA5);
    push_beat(MODE_BYTE, 8'h00);
    push_beat(MODE_BYTE, 8'hA5);
    push_beat(MODE_BYTE, 8'h09);
    // silence in the body: abort, the next byte opens a new frame
    push_beat(MODE_BYTE, 8'hA5);
    push_beat(MODE_BYTE, 8'h08);
    push_beat(MODE_BYTE, 8'h11);
    push_beat(MODE_TICK, 8'h00);
    push_beat(MODE_TICK, 8'h00);
    push_beat(MODE_BYTE, 8'hA5);
    push_beat(MODE_BYTE, 8'h01);
    push_beat(MODE_BYTE, 8'hA6);
    // silence with no frame open
    push_beat(MODE_TICK, 8'h00);
    push_beat(MODE_TICK, 8'h00);
    push_beat(MODE_BYTE, 8'h33);
    // silence while the length is awaited, then a bad checksum
    push_beat(MODE_BYTE, 8'hA5);
    push_beat(MODE_TICK, 8'h00);
    push_beat(MODE_TICK, 8'h00);
    push_beat(MODE_BYTE, 8'hA5);
    push_beat(MODE_BYTE, 8'h01);
    push_beat(MODE_BYTE, 8'h00);
    drain();

    load_settings(8'h00, 8'd255, 16'hFFFF);
    queue_traffic(400);
    hold_req = 1'b1;
    drain();

    load_settings(8'hFF, 8'd1, 16'd1);
    queue_traffic(250);
    drain();

    load_settings(8'h3C, 8'd0, 16'd5);
    queue_traffic(150);
    drain();

    load_settings(8'h3C, 8'd200, 16'd0);
    queue_traffic(100);
    drain();

    calm = 1'b1;
    load_settings(8'($urandom), 8'd20, 16'd20);
    queue_traffic(350);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
